@@ sv/sha1_pkg.sv @@
package sha1_pkg;

    typedef logic [31:0] word_t;

    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int BLOCK_WORDS  = 16;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

    // initial chaining values h0..h4
    localparam word_t IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round constants, one per group of twenty rounds
    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // sequencer commands to the round datapath
    typedef struct packed {
        logic load;       // copy chaining words into working variables
        logic step;       // run one round
        logic fold;       // add working variables back into chaining words
        logic init;       // restore initial chaining values
    } ctrl_t;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

@@ sv/sha1_sched.sv @@
module sha1_sched (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [5:0]        wr_pos,
    input  logic [7:0]        wr_byte,
    input  logic              shift,
    output sha1_pkg::word_t   w_cur
);
    import sha1_pkg::*;

    // sixteen-word window: holds the block while filling, then slides as W
    word_t w_reg [BLOCK_WORDS];
    word_t w_new;
    logic [1:0] lane;

    assign lane  = ~wr_pos[1:0];
    assign w_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign w_cur = w_reg[0];

    // write one byte big-endian into its word, or advance the schedule
    always_ff @(posedge aclk) begin
        if (shift) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= w_new;
        end else if (wr_en) begin
            w_reg[wr_pos[5:2]][{lane, 3'b000} +: 8] <= wr_byte;
        end
    end

endmodule

@@ sv/sha1_round.sv @@
module sha1_round (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha1_pkg::ctrl_t   ctrl,
    input  logic [6:0]        rnd,
    input  sha1_pkg::word_t   w_cur,
    output sha1_pkg::word_t   chain [sha1_pkg::DIGEST_WORDS]
);
    import sha1_pkg::*;

    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t h_reg [DIGEST_WORDS];
    word_t f, k, t_next;

    // pick round function and constant by round group
    always_comb begin
        if (rnd < 7'd20) begin
            f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k = K0;
        end else if (rnd < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end else if (rnd < 7'd60) begin
            f = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k = K2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
        t_next = rotl(a_reg, 5) + f + e_reg + k + w_cur;
    end

    // working variables
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (ctrl.step) begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.init) begin
            h_reg <= IV;
        end else if (ctrl.fold) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    assign chain = h_reg;

endmodule

@@ sv/sha1_stream_hash.sv @@
// Channel  Dir  Ports                                                    Beat
// s_       in   s_valid s_ready s_operation s_data_byte                  absorb byte or finish
// m_       out  m_valid m_ready m_digest_word m_word_index m_last_word   one digest word
//
// An absorb beat that completes a 64-byte block starts a compression: the
// single round datapath runs 80 rounds, one per cycle, then one fold.
// A finish beat writes the pad mark, pads to the end of the block and compresses it;
// an extra length block adds 64 more padding bytes and a compression. Five output beats follow.
// Reset is synchronous, active low, and loads the initial chaining values.
// s_ready stays low until the last digest word; m_ready low holds the current word.
module sha1_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  widx_reg, widx_next;
    logic        two_blk_reg, two_blk_next;
    logic        fin_reg, fin_next;
    logic        s_ready_reg, s_ready_next;
    logic        m_valid_reg, m_valid_next;

    ctrl_t       ctrl;
    logic        wr_en, shift;
    logic [7:0]  wr_byte;
    logic [63:0] len_bits;
    logic [2:0]  len_lane;
    logic        in_beat;
    word_t       w_cur;
    word_t       chain [DIGEST_WORDS];

    assign in_beat  = s_valid && s_ready_reg;
    assign len_bits = {len_reg, 3'b000};
    assign len_lane = ~pos_reg[2:0];

    // sequencer
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        rnd_next     = rnd_reg;
        widx_next    = widx_reg;
        two_blk_next = two_blk_reg;
        fin_next     = fin_reg;
        ctrl         = '0;
        wr_en        = 1'b0;
        wr_byte      = 8'h00;
        shift        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + 6'd1;
                    if (s_operation) begin
                        // finish: drop in the pad mark, then padding
                        wr_byte      = PAD_MARK;
                        fin_next     = 1'b1;
                        two_blk_next = (pos_reg > 6'd55);
                        state_next   = S_PAD;
                    end else begin
                        wr_byte  = s_data_byte;
                        len_next = len_reg + 61'd1;
                    end
                    if (pos_reg == 6'd63) begin
                        ctrl.load  = 1'b1;
                        rnd_next   = '0;
                        state_next = S_ROUND;
                    end
                end
            end
            S_PAD: begin
                // zero fill, with the bit length in the final eight bytes of the last block
                wr_en    = 1'b1;
                pos_next = pos_reg + 6'd1;
                if (pos_reg >= 6'd56 && !two_blk_reg) begin
                    wr_byte = len_bits[{len_lane, 3'b000} +: 8];
                end
                if (pos_reg == 6'd63) begin
                    ctrl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                ctrl.step = 1'b1;
                shift     = 1'b1;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                ctrl.fold = 1'b1;
                if (!fin_reg) begin
                    state_next = S_IDLE;
                end else if (two_blk_reg) begin
                    two_blk_next = 1'b0;
                    state_next   = S_PAD;
                end else begin
                    widx_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'(DIGEST_WORDS - 1)) begin
                        ctrl.init  = 1'b1;
                        len_next   = '0;
                        fin_next   = 1'b0;
                        widx_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        s_ready_next = (state_next == S_IDLE);
        m_valid_next = (state_next == S_OUT);
    end

    // hold state and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            rnd_reg     <= '0;
            widx_reg    <= '0;
            two_blk_reg <= 1'b0;
            fin_reg     <= 1'b0;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            rnd_reg     <= rnd_next;
            widx_reg    <= widx_next;
            two_blk_reg <= two_blk_next;
            fin_reg     <= fin_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    sha1_sched u_sched (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_pos  (pos_reg),
        .wr_byte (wr_byte),
        .shift   (shift),
        .w_cur   (w_cur)
    );

    sha1_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .rnd     (rnd_reg),
        .w_cur   (w_cur),
        .chain   (chain)
    );

    assign s_ready       = s_ready_reg;
    assign m_valid       = m_valid_reg;
    assign m_digest_word = chain[widx_reg];
    assign m_word_index  = widx_reg;
    assign m_last_word   = (widx_reg == 3'(DIGEST_WORDS - 1));

endmodule

@@ sv/sha1_stream_hash_chk.sv @@
module sha1_stream_hash_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_operation,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);

    // never take input while a digest is being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready and m_valid high together");

    // stalled digest word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index))
        else $error("digest beat changed while stalled");

    // words come back to back in index order
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word
        |=> m_valid && (m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest word index did not advance");

    // after the last word the block is ready for a new message
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> s_ready && !m_valid)
        else $error("block not idle after last digest word");

    // a finish beat blocks further input
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation |=> !s_ready)
        else $error("input taken right after finish");

endmodule

bind sha1_stream_hash sha1_stream_hash_chk u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_operation   (s_operation),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);
